[hdl/trpd_pkg.sv]
// ----------------------------------------------------------------------------
// trpd_pkg: shared types and constants
// Field widths, register indexes, reset values and the structs that pass the
// configuration and the decoded result between the decoder's modules.
// ----------------------------------------------------------------------------
package trpd_pkg;

    localparam int DUR_W     = 24;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CODE_W    = 15;
    localparam int RAW_W     = 18;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_MIN   = 3'd4;

    localparam logic [CFG_W-1:0] RST_LONG_MIN  = 16'd800;
    localparam logic [CFG_W-1:0] RST_LONG_MAX  = 16'd1800;
    localparam logic [CFG_W-1:0] RST_SHORT_MIN = 16'd200;
    localparam logic [CFG_W-1:0] RST_SHORT_MAX = 16'd700;
    localparam logic [CFG_W-1:0] RST_GAP_MIN   = 16'd5000;

    typedef struct packed {
        logic [CFG_W-1:0] long_min;
        logic [CFG_W-1:0] long_max;
        logic [CFG_W-1:0] short_min;
        logic [CFG_W-1:0] short_max;
        logic [CFG_W-1:0] gap_min;
    } t_cfg;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [RAW_W-1:0]  raw_symbols;
    } t_result;

endpackage

[hdl/trpd_cfg.sv]
// ----------------------------------------------------------------------------
// trpd_cfg: timing window registers
// Holds the pulse and gap thresholds, loaded through a plain write port.
// ----------------------------------------------------------------------------
module trpd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [trpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [trpd_pkg::CFG_W-1:0]      i_cfg_data,
    output trpd_pkg::t_cfg                  o_cfg
);
    import trpd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_min  <= RST_LONG_MIN;
            r_cfg.long_max  <= RST_LONG_MAX;
            r_cfg.short_min <= RST_SHORT_MIN;
            r_cfg.short_max <= RST_SHORT_MAX;
            r_cfg.gap_min   <= RST_GAP_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LONG_MIN:  r_cfg.long_min  <= i_cfg_data;
                REG_LONG_MAX:  r_cfg.long_max  <= i_cfg_data;
                REG_SHORT_MIN: r_cfg.short_min <= i_cfg_data;
                REG_SHORT_MAX: r_cfg.short_max <= i_cfg_data;
                REG_GAP_MIN:   r_cfg.gap_min   <= i_cfg_data;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/trpd_frame.sv]
// ----------------------------------------------------------------------------
// trpd_frame: frame tracker and trit decoder
// Classes each pulse, shifts symbols into the store and folds every completed
// symbol pair into a running base-3 code, so the result is ready at the gap.
// ----------------------------------------------------------------------------
module trpd_frame #(
    parameter int TRITS = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic                        i_level,
    input  logic [trpd_pkg::DUR_W-1:0]  i_duration,
    input  trpd_pkg::t_cfg              i_cfg,
    output logic                        o_res_valid,
    output trpd_pkg::t_result           o_res
);
    import trpd_pkg::*;

    localparam int SYMS  = 2 * TRITS;
    localparam int CNT_W = $clog2(SYMS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SYMS);

    logic               r_receiving, n_receiving;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SYMS-1:0]    r_store, n_store;
    logic [CODE_W-1:0]  r_code, n_code;
    logic               r_bad, n_bad;

    logic               w_is_long, w_is_short, w_is_gap, w_sym;
    logic [1:0]         w_trit;
    logic               w_pair_bad;
    logic [CODE_W-1:0]  w_base, w_code_step;
    logic [SYMS+RAW_W-1:0] w_raw_ext;

    assign w_is_long  = (i_duration >= DUR_W'(i_cfg.long_min))
                     && (i_duration <= DUR_W'(i_cfg.long_max));
    assign w_is_short = (i_duration >= DUR_W'(i_cfg.short_min))
                     && (i_duration <= DUR_W'(i_cfg.short_max));
    assign w_is_gap   = (i_duration >= DUR_W'(i_cfg.gap_min));
    assign w_sym      = w_is_long;

    // first symbol of the pair sits in the store LSB
    assign w_trit      = {1'b0, r_store[0]} + {1'b0, w_sym};
    assign w_pair_bad  = !r_store[0] && w_sym;
    assign w_base      = (r_count == CNT_W'(1)) ? '0 : r_code;
    assign w_code_step = {w_base[CODE_W-2:0], 1'b0} + w_base + CODE_W'(w_trit);

    always_comb begin
        n_receiving = r_receiving;
        n_count     = r_count;
        n_store     = r_store;
        n_code      = r_code;
        n_bad       = r_bad;
        o_res_valid = 1'b0;
        if (i_fire) begin
            if (i_level) begin
                if (r_receiving) begin
                    if (w_is_long || w_is_short) begin
                        if (r_count < CNT_FULL) begin
                            n_store = {r_store[SYMS-2:0], w_sym};
                            n_count = r_count + CNT_W'(1);
                            if (r_count[0]) begin
                                n_code = w_code_step;
                                n_bad  = ((r_count == CNT_W'(1)) ? 1'b0 : r_bad)
                                       | w_pair_bad;
                            end
                        end
                    end else begin
                        // out of both windows: abort
                        n_receiving = 1'b0;
                        n_count     = '0;
                    end
                end
            end else if (w_is_gap) begin
                n_receiving = !r_receiving;
                n_count     = '0;
                o_res_valid = r_receiving && (r_count == CNT_FULL) && !r_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving <= 1'b0;
            r_count     <= '0;
        end else begin
            r_receiving <= n_receiving;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_store <= n_store;
        r_code  <= n_code;
        r_bad   <= n_bad;
    end

    assign w_raw_ext         = {{RAW_W{1'b0}}, r_store};
    assign o_res.code        = r_code;
    assign o_res.raw_symbols = w_raw_ext[RAW_W-1:0];

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("symbol count beyond frame length");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_receiving |-> (r_count == '0))
        else $error("symbols held while waiting for a gap");

    a_res_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_receiving && r_count == CNT_FULL && !i_level))
        else $error("result from an incomplete frame");
`endif

endmodule

[hdl/trpd_obuf.sv]
// ----------------------------------------------------------------------------
// trpd_obuf: result register with skid stage
// Two-entry output buffer: the head drives the output channel, the skid entry
// catches a result produced while the head is stalled.
// ----------------------------------------------------------------------------
module trpd_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  trpd_pkg::t_result   i_res,
    input  logic                i_stall,
    output logic                o_valid,
    output trpd_pkg::t_result   o_res,
    output logic                o_full
);
    import trpd_pkg::*;

    logic    r_head_v, n_head_v;
    logic    r_skid_v, n_skid_v;
    t_result r_head, n_head;
    t_result r_skid, n_skid;
    logic    w_pop;

    assign w_pop = r_head_v && !i_stall;

    always_comb begin
        n_head_v = r_head_v;
        n_skid_v = r_skid_v;
        n_head   = r_head;
        n_skid   = r_skid;
        if (w_pop) begin
            if (r_skid_v) begin
                n_head   = r_skid;
                n_head_v = 1'b1;
                n_skid   = i_res;
                n_skid_v = i_push;
            end else begin
                n_head   = i_res;
                n_head_v = i_push;
            end
        end else if (i_push) begin
            if (!r_head_v) begin
                n_head   = i_res;
                n_head_v = 1'b1;
            end else begin
                n_skid   = i_res;
                n_skid_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_head_v <= n_head_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_valid = r_head_v;
    assign o_res   = r_head;
    assign o_full  = r_head_v && r_skid_v;

`ifndef NO_ASSERTIONS
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_head_v)
        else $error("skid entry held with empty head");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head_v && r_skid_v && i_stall) |-> !i_push)
        else $error("result pushed into a full buffer");
`endif

endmodule

[hdl/trinary_remote_pulse_decoder.sv]
// ----------------------------------------------------------------------------
// trinary_remote_pulse_decoder: OOK tristate remote code decoder
// Turns level/duration intervals into nine-trit switch codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one item per interval, i_level high for
//   a carrier pulse and low for a gap, i_duration in microseconds.
//   Output channel (o_valid / i_stall): one item per valid frame, carrying the
//   base-3 code and the raw symbol bits.
//   Config port: write i_cfg_data to register i_cfg_index while i_cfg_we is
//   high; write only while the block is idle.
//   Throughput: one input item per cycle while the output buffer has room.
//   The item is registered, then classified and folded into the frame state
//   once the buffer has room; the closing gap's result is registered in it.
//   Each item costs one pass through the window compares, and each completed
//   symbol pair one 15-bit multiply-by-three-and-add step.
//   Reset puts the thresholds to their defaults and the block waits for an
//   arming gap. If the receiver stalls, up to two results are held; input
//   stalls only when both are full and an item is waiting to be decoded.
// ----------------------------------------------------------------------------
module trinary_remote_pulse_decoder #(
    parameter int TRITS = 9
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_level,
    input  logic [trpd_pkg::DUR_W-1:0]      i_duration,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [trpd_pkg::CODE_W-1:0]     o_code,
    output logic [trpd_pkg::RAW_W-1:0]      o_raw_symbols,
    input  logic                            i_cfg_we,
    input  logic [trpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [trpd_pkg::CFG_W-1:0]      i_cfg_data
);
    import trpd_pkg::*;

    t_cfg             w_cfg;
    t_result          w_res, w_out;
    logic             w_res_valid;
    logic             w_full;
    logic             w_fire;
    logic             w_accept;

    logic             r_in_valid;
    logic             r_in_level;
    logic [DUR_W-1:0] r_in_duration;

    // decode the held item whenever the output buffer has room
    assign w_fire   = r_in_valid && !w_full;
    assign o_stall  = r_in_valid && w_full;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_level    <= i_level;
            r_in_duration <= i_duration;
        end
    end

    trpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    trpd_frame #(
        .TRITS (TRITS)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_level     (r_in_level),
        .i_duration  (r_in_duration),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    trpd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (w_out),
        .o_full  (w_full)
    );

    assign o_code        = w_out.code;
    assign o_raw_symbols = w_out.raw_symbols;

`ifndef NO_ASSERTIONS
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && r_in_valid))
        else $error("input stalled with room in the output buffer");

    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_full) |=> r_in_valid)
        else $error("waiting item dropped while output buffer full");
`endif

endmodule

[sim/trinary_remote_pulse_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trinary_remote_pulse_decoder_tb: self-checking bench for the pulse decoder
// Feeds arming gaps, symbol pulses and closing gaps under several window
// settings, tracks the frame state alongside the block and compares every
// decoded code and raw symbol word with the one the tracker worked out.
// ----------------------------------------------------------------------------
module trinary_remote_pulse_decoder_tb;
    import trpd_pkg::*;

    localparam int TRITS          = 9;
    localparam int SYMS           = 2 * TRITS;
    localparam int DUR_MAX        = (1 << DUR_W) - 1;
    localparam int ITEMS          = 800;
    localparam int SETTLE         = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef enum {
        FRAME_GOOD,
        FRAME_BAD_PAIR,
        FRAME_ABORT,
        FRAME_SHORT,
        FRAME_LONG,
        FRAME_UNARMED
    } t_frame_kind;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 i_level       = 1'b0;
    logic [DUR_W-1:0]     i_duration    = '0;
    logic                 i_stall       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [CODE_W-1:0]    o_code;
    logic [RAW_W-1:0]     o_raw_symbols;

    // Tracks armed state and stored symbols, and holds the codes still owed.
    class t_code_tracker;
        t_cfg             regs;
        bit               receiving;
        int unsigned      sym_count;
        logic [SYMS-1:0]  sym_bits;
        t_result          pending_codes[$];
        int               mismatches;

        function new();
            regs = '{long_min: RST_LONG_MIN, long_max: RST_LONG_MAX,
                     short_min: RST_SHORT_MIN, short_max: RST_SHORT_MAX,
                     gap_min: RST_GAP_MIN};
            receiving       = 1'b0;
            sym_count       = 0;
            sym_bits        = '0;
            mismatches      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_LONG_MIN:  regs.long_min  = data;
                REG_LONG_MAX:  regs.long_max  = data;
                REG_SHORT_MIN: regs.short_min = data;
                REG_SHORT_MAX: regs.short_max = data;
                REG_GAP_MIN:   regs.gap_min   = data;
                default: ;
            endcase
        endfunction

        function void take_interval(logic level, logic [DUR_W-1:0] dur);
            bit      sym;
            bit      a;
            bit      b;
            bit      ok;
            int      code;
            t_result r;
            if (level) begin
                if (!receiving)
                    return;
                // long window is tried first
                if (dur >= regs.long_min && dur <= regs.long_max) begin
                    sym = 1'b1;
                end else if (dur >= regs.short_min && dur <= regs.short_max) begin
                    sym = 1'b0;
                end else begin
                    receiving = 1'b0;
                    sym_count = 0;
                    return;
                end
                if (sym_count < SYMS) begin
                    sym_bits[SYMS-1-sym_count] = sym;
                    sym_count++;
                end
                return;
            end
            if (dur < regs.gap_min)
                return;
            if (!receiving) begin
                receiving = 1'b1;
                sym_count = 0;
                return;
            end
            if (sym_count == SYMS) begin
                ok   = 1'b1;
                code = 0;
                for (int t = 0; t < TRITS; t++) begin
                    a = sym_bits[SYMS-1-2*t];
                    b = sym_bits[SYMS-2-2*t];
                    if (!a && b)
                        ok = 1'b0;
                    code = code * 3 + a + b;
                end
                if (ok) begin
                    r.code        = code[CODE_W-1:0];
                    r.raw_symbols = sym_bits;
                    pending_codes.push_back(r);
                end
            end
            receiving = 1'b0;
            sym_count = 0;
        endfunction

        task report(string msg);
            $display("%0t ns  mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_frame(logic [CODE_W-1:0] code, logic [RAW_W-1:0] raw);
            t_result want;
            if (pending_codes.size() == 0) begin
                report($sformatf("code %0d raw %05h with no frame owed", code, raw));
                return;
            end
            want = pending_codes.pop_front();
            if (code !== want.code)
                report($sformatf("code %0d, expected %0d", code, want.code));
            if (raw !== want.raw_symbols)
                report($sformatf("raw symbols %05h, expected %05h", raw, want.raw_symbols));
        endtask
    endclass

    t_code_tracker sb = new();

    int items_sent  = 0;
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;
    bit pressure_on = 1'b0;
    bit hold_req    = 1'b0;

    trinary_remote_pulse_decoder #(
        .TRITS(TRITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_level      (i_level),
        .i_duration   (i_duration),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code       (o_code),
        .o_raw_symbols(o_raw_symbols),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Interval generation
    // ------------------------------------------------------------------
    function automatic logic [DUR_W-1:0] pulse_for(bit sym);
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        lo = sym ? sb.regs.long_min : sb.regs.short_min;
        hi = sym ? sb.regs.long_max : sb.regs.short_max;
        if (lo > hi)
            return DUR_W'($urandom_range(16'hFFFF, 0));
        return DUR_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic [DUR_W-1:0] out_of_window();
        int top;
        int lowest;
        top    = int'((sb.regs.long_max > sb.regs.short_max) ? sb.regs.long_max
                                                             : sb.regs.short_max);
        lowest = int'((sb.regs.long_min < sb.regs.short_min) ? sb.regs.long_min
                                                             : sb.regs.short_min);
        if (lowest > 0 && $urandom_range(1, 0))
            return DUR_W'($urandom_range(lowest - 1, 0));
        return DUR_W'($urandom_range(DUR_MAX, top + 1));
    endfunction

    function automatic logic [DUR_W-1:0] frame_gap();
        if ($urandom_range(1, 0))
            return DUR_W'(sb.regs.gap_min + $urandom_range(64, 0));
        return DUR_W'($urandom_range(DUR_MAX, sb.regs.gap_min));
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.short_min = CFG_W'($urandom_range(400, 0));
        c.short_max = CFG_W'(c.short_min + $urandom_range(600, 50));
        c.long_min  = CFG_W'(c.short_max + $urandom_range(300, 1));
        c.long_max  = CFG_W'(c.long_min + $urandom_range(3000, 0));
        c.gap_min   = CFG_W'(c.long_max + $urandom_range(20000, 1));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_interval(input logic level, input logic [DUR_W-1:0] dur);
        int gap;
        gap = tx_idle_on ? $urandom_range(17, 0) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_level    <= level;
        i_duration <= dur;
        do @(posedge i_clk); while (o_stall);
        sb.take_interval(level, dur);
        items_sent++;
    endtask

    // Drop valid and let every owed code arrive before going on.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_codes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic program_regs(input t_cfg c);
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: begin idx = REG_LONG_MIN;  val = c.long_min;  end
                1: begin idx = REG_LONG_MAX;  val = c.long_max;  end
                2: begin idx = REG_SHORT_MIN; val = c.short_min; end
                3: begin idx = REG_SHORT_MAX; val = c.short_max; end
                4: begin idx = REG_GAP_MIN;   val = c.gap_min;   end
                default: begin
                    // index past the register list, must be ignored
                    idx = CFG_IDX_W'(REG_GAP_MIN + 1 + $urandom_range(2, 0));
                    val = CFG_W'($urandom);
                end
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            @(posedge i_clk);
            sb.write_reg(idx, val);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input t_frame_kind kind);
        logic [SYMS-1:0] bits;
        int              nsym;
        int              bad_trit;
        int              abort_at;
        bit              sym;
        nsym     = SYMS;
        bad_trit = -1;
        abort_at = -1;
        for (int t = 0; t < TRITS; t++) begin
            case ($urandom_range(2, 0))
                0:       bits[SYMS-1-2*t -: 2] = 2'b00;
                1:       bits[SYMS-1-2*t -: 2] = 2'b10;
                default: bits[SYMS-1-2*t -: 2] = 2'b11;
            endcase
        end
        case (kind)
            FRAME_BAD_PAIR: bad_trit = $urandom_range(TRITS - 1, 0);
            FRAME_ABORT:    abort_at = $urandom_range(SYMS - 1, 0);
            FRAME_SHORT:    nsym     = $urandom_range(SYMS - 1, 0);
            FRAME_LONG:     nsym     = SYMS + $urandom_range(4, 1);
            default: ;
        endcase
        if (bad_trit >= 0)
            bits[SYMS-1-2*bad_trit -: 2] = 2'b01;
        // close a half-filled frame left by noise, then arm
        if (sb.receiving && sb.sym_count != 0)
            send_interval(1'b0, frame_gap());
        if (!sb.receiving && kind != FRAME_UNARMED)
            send_interval(1'b0, frame_gap());
        for (int k = 0; k < nsym; k++) begin
            if (k == abort_at)
                send_interval(1'b1, out_of_window());
            sym = (k < SYMS) ? bits[SYMS-1-k] : bit'($urandom_range(1, 0));
            send_interval(1'b1, pulse_for(sym));
            if (sb.regs.gap_min != 0 && $urandom_range(1, 0))
                send_interval(1'b0, DUR_W'($urandom_range(sb.regs.gap_min - 1, 0)));
        end
        send_interval(1'b0, frame_gap());
    endtask

    task automatic run_frames(input int target);
        t_frame_kind kind;
        int          pick;
        while (items_sent < target) begin
            if (!pressure_on) begin
                tx_idle_on = ($urandom_range(3, 0) != 0);
                rx_idle_on = ($urandom_range(3, 0) != 0);
            end
            pick = $urandom_range(99, 0);
            if (pressure_on || pick < 70)
                kind = FRAME_GOOD;
            else if (pick < 76)
                kind = FRAME_BAD_PAIR;
            else if (pick < 82)
                kind = FRAME_ABORT;
            else if (pick < 88)
                kind = FRAME_SHORT;
            else if (pick < 94)
                kind = FRAME_LONG;
            else
                kind = FRAME_UNARMED;
            send_frame(kind);
            if ($urandom_range(3, 0) == 0)
                repeat ($urandom_range(3, 1))
                    send_interval(1'(($urandom_range(1, 0))), DUR_W'($urandom));
            if ($urandom_range(9, 0) == 0)
                drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall per code, long hold on request
    // ------------------------------------------------------------------
    initial begin : code_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                sb.check_frame(o_code, o_raw_symbols);
                stall_left = rx_idle_on ? $urandom_range(17, 0) : 0;
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset thresholds
        send_interval(1'b1, 24'd1000);          // pulse while waiting
        send_interval(1'b0, 24'd0);
        send_interval(1'b0, 24'd4999);          // just short of a frame gap
        send_interval(1'b0, 24'hFFFFFF);        // arm
        for (int k = 0; k < SYMS; k++) begin
            send_interval(1'b1, k[0] ? 24'd1800 : 24'd800);
            if (k == TRITS)
                send_interval(1'b0, 24'd4999);  // short gap while receiving
        end
        send_interval(1'b1, 24'd700);           // one symbol too many
        send_interval(1'b0, 24'd5000);          // highest code
        send_interval(1'b0, 24'd5000);
        send_interval(1'b1, 24'd200);
        send_interval(1'b1, 24'd799);           // between the windows: abort
        send_interval(1'b1, 24'hFFFFFF);
        send_interval(1'b0, 24'd5000);
        send_interval(1'b1, 24'd700);
        send_interval(1'b0, 24'd65535);         // closes with too few symbols
        drain();

        program_regs(t_cfg'{long_min: 16'd1000, long_max: 16'd2000, short_min: 16'd300,
                            short_max: 16'd800, gap_min: 16'd4000});
        run_frames(250);
        drain();

        // every pulse up to 16'hFFFF long, short window empty, every gap a frame gap
        program_regs(t_cfg'{long_min: 16'h0000, long_max: 16'hFFFF, short_min: 16'hFFFF,
                            short_max: 16'h0000, gap_min: 16'h0000});
        run_frames(350);
        drain();

        // long window empty, every pulse up to 16'hFFFF short
        program_regs(t_cfg'{long_min: 16'hFFFF, long_max: 16'h0000, short_min: 16'h0000,
                            short_max: 16'hFFFF, gap_min: 16'hFFFF});
        run_frames(450);
        drain();

        // overlapping windows
        program_regs(t_cfg'{long_min: 16'd500, long_max: 16'd1500, short_min: 16'd100,
                            short_max: 16'd1000, gap_min: 16'd3000});
        run_frames(550);
        drain();

        // back-to-back frames against a held-off receiver
        program_regs(t_cfg'{long_min: RST_LONG_MIN, long_max: RST_LONG_MAX,
                            short_min: RST_SHORT_MIN, short_max: RST_SHORT_MAX,
                            gap_min: RST_GAP_MIN});
        pressure_on = 1'b1;
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        hold_req    = 1'b1;
        run_frames(items_sent + 150);
        pressure_on = 1'b0;
        drain();

        while (items_sent < ITEMS) begin
            program_regs(random_cfg());
            run_frames(items_sent + 120);
            drain();
        end

        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
